/* sv/btrp_pkg.sv */
// Shared types and character constants for the Bluetooth module response parser.
package btrp_pkg;

    // Parser states, one-hot coded.
    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_OKWAIT  = 6'b000010,
        ST_ERRTAG  = 6'b000100,
        ST_PLUSTAG = 6'b001000,
        ST_DATA    = 6'b010000,
        ST_SKIP    = 6'b100000
    } parse_state_t;

    // Event codes reported with each result.
    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_OK           = 3'd1,
        EV_ERROR        = 3'd2,
        EV_PAIR         = 3'd3,
        EV_INCOMING     = 3'd4,
        EV_CONNECTED    = 3'd5,
        EV_DISCONNECTED = 3'd6,
        EV_DATA         = 3'd7
    } event_t;

    // One result item as it leaves the parser core.
    typedef struct packed {
        event_t     event_res;
        logic [7:0] error_code;
        logic [7:0] payload_byte;
        logic       link_up;
        logic       parser_idle;
    } result_t;

    // Four-character tags, first received character in the top byte.
    localparam logic [31:0] TAG_ERR  = "RR=-";
    localparam logic [31:0] TAG_RSLE = "RSLE";
    localparam logic [31:0] TAG_RCOI = "RCOI";
    localparam logic [31:0] TAG_RCCR = "RCCR";
    localparam logic [31:0] TAG_RDII = "RDII";
    localparam logic [31:0] TAG_RDAI = "RDAI";

    // Single characters that steer the parser.
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_E       = 8'h45;
    localparam logic [7:0] CH_O       = 8'h4F;
    localparam logic [7:0] CH_K       = 8'h4B;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    // Number of characters in a tag and the length field layout.
    localparam logic [2:0] TAG_LEN     = 3'd4;
    localparam logic [2:0] PHASE_COMMA = 3'd3;
    localparam logic [2:0] PHASE_BODY  = 3'd4;

endpackage

/* sv/btrp_core.sv */
// Parser state registers and the combinational next-state and result logic.
module btrp_core
    import btrp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic [7:0] rx_byte,
    output result_t    result
);

    parse_state_t state_reg, state_next;
    logic [2:0]   tag_index_reg, tag_index_next;
    logic [7:0]   tag_buf_reg [4];
    logic [2:0]   length_phase_reg, length_phase_next;
    logic [9:0]   payload_left_reg, payload_left_next;
    logic         connected_reg, connected_next;

    logic         tag_wr;
    logic [31:0]  tag_word;
    logic [7:0]   digit;
    logic [9:0]   digit_term;
    logic [9:0]   left_dec;
    event_t       event_val;
    logic [7:0]   error_val;
    logic [7:0]   payload_val;

    // The stored tag as one word, first character in the top byte.
    assign tag_word = {tag_buf_reg[0], tag_buf_reg[1], tag_buf_reg[2], tag_buf_reg[3]};
    assign digit    = rx_byte - CH_ZERO;
    assign left_dec = payload_left_reg - 10'd1;

    // Weighted value of one length digit; only used when the digit is 0 to 9.
    always_comb begin
        case (length_phase_reg)
            3'd0:    digit_term = {6'b0, digit[3:0]} * 10'd100;
            3'd1:    digit_term = {6'b0, digit[3:0]} * 10'd10;
            default: digit_term = {6'b0, digit[3:0]};
        endcase
    end

    // Next state and result for the byte being consumed.
    always_comb begin
        state_next        = state_reg;
        tag_index_next    = tag_index_reg;
        length_phase_next = length_phase_reg;
        payload_left_next = payload_left_reg;
        connected_next    = connected_reg;
        tag_wr            = 1'b0;
        event_val         = EV_NONE;
        error_val         = 8'd0;
        payload_val       = 8'd0;

        case (state_reg)
            ST_OKWAIT: begin
                if (rx_byte == CH_K) begin
                    event_val = EV_OK;
                end
                state_next = ST_SKIP;
            end
            ST_ERRTAG: begin
                if (tag_index_reg < TAG_LEN) begin
                    tag_wr         = 1'b1;
                    tag_index_next = tag_index_reg + 3'd1;
                end else begin
                    if (tag_word == TAG_ERR) begin
                        event_val = EV_ERROR;
                        error_val = digit;
                    end
                    state_next = ST_SKIP;
                end
            end
            ST_PLUSTAG: begin
                if (tag_index_reg < TAG_LEN) begin
                    tag_wr         = 1'b1;
                    tag_index_next = tag_index_reg + 3'd1;
                end else begin
                    state_next = ST_SKIP;
                    if (tag_word == TAG_RSLE) begin
                        event_val = EV_PAIR;
                    end else if (tag_word == TAG_RCOI) begin
                        event_val = EV_INCOMING;
                    end else if (tag_word == TAG_RCCR) begin
                        event_val      = EV_CONNECTED;
                        connected_next = 1'b1;
                    end else if (tag_word == TAG_RDII) begin
                        event_val      = EV_DISCONNECTED;
                        connected_next = 1'b0;
                    end else if (tag_word == TAG_RDAI) begin
                        state_next        = ST_DATA;
                        length_phase_next = 3'd0;
                        payload_left_next = 10'd0;
                    end
                end
            end
            ST_DATA: begin
                if (length_phase_reg < PHASE_COMMA) begin
                    // One decimal digit of the length field.
                    if (digit > 8'd9) begin
                        state_next = ST_IDLE;
                    end else begin
                        payload_left_next = payload_left_reg + digit_term;
                    end
                    length_phase_next = length_phase_reg + 3'd1;
                end else if (length_phase_reg == PHASE_COMMA) begin
                    length_phase_next = PHASE_BODY;
                    if (rx_byte != CH_COMMA) begin
                        state_next = ST_IDLE;
                    end else if (payload_left_reg == 10'd0) begin
                        state_next = ST_SKIP;
                    end
                end else begin
                    // Payload byte passed through.
                    event_val         = EV_DATA;
                    payload_val       = rx_byte;
                    payload_left_next = left_dec;
                    if (left_dec == 10'd0) begin
                        state_next = ST_SKIP;
                    end
                end
            end
            ST_SKIP: begin
                if (rx_byte == CH_NEWLINE) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                // Idle: look for the first character of a response.
                state_next = ST_IDLE;
                if (rx_byte == CH_PLUS) begin
                    state_next     = ST_PLUSTAG;
                    tag_index_next = 3'd0;
                end else if (rx_byte == CH_E) begin
                    state_next     = ST_ERRTAG;
                    tag_index_next = 3'd0;
                end else if (rx_byte == CH_O) begin
                    state_next = ST_OKWAIT;
                end
            end
        endcase
    end

    // Result of this byte, reported with the state it leaves behind.
    always_comb begin
        result.event_res    = event_val;
        result.error_code   = error_val;
        result.payload_byte = payload_val;
        result.link_up      = connected_next;
        result.parser_idle  = (state_next == ST_IDLE);
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            tag_index_reg    <= 3'd0;
            length_phase_reg <= 3'd0;
            payload_left_reg <= 10'd0;
            connected_reg    <= 1'b0;
        end else if (step_en) begin
            state_reg        <= state_next;
            tag_index_reg    <= tag_index_next;
            length_phase_reg <= length_phase_next;
            payload_left_reg <= payload_left_next;
            connected_reg    <= connected_next;
        end
    end

    // Tag characters; a tag is compared only after all four are written.
    always_ff @(posedge aclk) begin
        if (step_en && tag_wr) begin
            tag_buf_reg[tag_index_reg[1:0]] <= rx_byte;
        end
    end

endmodule

/* sv/bt_module_response_parser.sv */
// Top level of the Bluetooth module response parser with its stream ports.
//
// Takes one received character per input transfer and returns exactly one
// result transfer for it. A character passes an input register, then the
// parser updates its state and the result register in the same cycle, so the
// block sustains one character per clock while the result side does not
// stall. Both registers hold their contents while the result side stalls, and
// a new character is taken whenever the input register is empty or moving on.
// Results report the event code on m_tuser; link_up and parser_idle give the
// connection flag and parser state after that character.
module bt_module_response_parser
    import btrp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] error_code, [15:8] payload_byte,
                                   // [16] link_up, [17] parser_idle, [23:18] zero
    output logic [2:0]  m_tuser    // [2:0] event_res
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    result_t    core_result;
    logic       out_ready;
    logic       advance;
    logic       s_take;

    // Handshake: the result register frees up when empty or being drained.
    assign out_ready = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign s_take    = s_tvalid && s_tready;

    btrp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .rx_byte (in_byte_reg),
        .result  (core_result)
    );

    // Valid flags of the two register stages.
    always_comb begin
        in_valid_next  = s_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers of the two stages.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_reg <= core_result;
        end
    end

    // Result transfer packing.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_res;
    assign m_tdata  = {6'b0, out_reg.parser_idle, out_reg.link_up,
                       out_reg.payload_byte, out_reg.error_code};

endmodule

/* tb/bt_module_response_parser_tb.sv */
// Self-checking testbench for the Bluetooth module response parser stream block.
`timescale 1ns / 1ps

module bt_module_response_parser_tb
    import btrp_pkg::*;
();

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_BYTES  = 150;

    // Tracks the parser state, predicts one result per received character and
    // compares the results that leave the block in order.
    class parser_scoreboard;
        parse_state_t rx_state;
        logic [2:0]   tag_count;
        logic [7:0]   tag_chars [4];
        logic [2:0]   length_phase;
        logic [9:0]   payload_left;
        logic         connected;
        result_t      expected_results [$];
        int           mismatches;
        int           results_checked;
        int           event_count [8];

        function new();
            rx_state     = ST_IDLE;
            tag_count    = '0;
            length_phase = '0;
            payload_left = '0;
            connected    = 1'b0;
            mismatches   = 0;
            results_checked = 0;
            foreach (tag_chars[i]) tag_chars[i] = '0;
            foreach (event_count[i]) event_count[i] = 0;
        endfunction

        // Stores one tag character; returns one once all four are in.
        function bit tag_full(logic [7:0] c);
            if (tag_count < TAG_LEN) begin
                tag_chars[tag_count[1:0]] = c;
                tag_count = tag_count + 3'd1;
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function logic [31:0] tag_word();
            return {tag_chars[0], tag_chars[1], tag_chars[2], tag_chars[3]};
        endfunction

        // Advances the predicted parser by one character.
        function result_t parse_byte(logic [7:0] c);
            result_t     r;
            logic [7:0]  digit;
            logic [9:0]  weight;
            r = '0;
            r.event_res = EV_NONE;
            digit = c - CH_ZERO;
            case (rx_state)
                ST_OKWAIT: begin
                    if (c == CH_K) r.event_res = EV_OK;
                    rx_state = ST_SKIP;
                end
                ST_ERRTAG: begin
                    if (tag_full(c)) begin
                        if (tag_word() == TAG_ERR) begin
                            r.event_res  = EV_ERROR;
                            r.error_code = digit;
                        end
                        rx_state = ST_SKIP;
                    end
                end
                ST_PLUSTAG: begin
                    if (tag_full(c)) begin
                        rx_state = ST_SKIP;
                        if (tag_word() == TAG_RSLE) begin
                            r.event_res = EV_PAIR;
                        end else if (tag_word() == TAG_RCOI) begin
                            r.event_res = EV_INCOMING;
                        end else if (tag_word() == TAG_RCCR) begin
                            r.event_res = EV_CONNECTED;
                            connected = 1'b1;
                        end else if (tag_word() == TAG_RDII) begin
                            r.event_res = EV_DISCONNECTED;
                            connected = 1'b0;
                        end else if (tag_word() == TAG_RDAI) begin
                            rx_state     = ST_DATA;
                            length_phase = '0;
                            payload_left = '0;
                        end
                    end
                end
                ST_DATA: begin
                    if (length_phase < PHASE_COMMA) begin
                        // Three decimal digits, most significant first.
                        if (digit > 8'd9) begin
                            rx_state = ST_IDLE;
                        end else begin
                            weight = (length_phase == 3'd0) ? 10'd100 :
                                     (length_phase == 3'd1) ? 10'd10 : 10'd1;
                            payload_left = payload_left + weight * digit[3:0];
                        end
                        length_phase = length_phase + 3'd1;
                    end else if (length_phase == PHASE_COMMA) begin
                        length_phase = PHASE_BODY;
                        if (c != CH_COMMA) rx_state = ST_IDLE;
                        else if (payload_left == '0) rx_state = ST_SKIP;
                    end else begin
                        r.event_res    = EV_DATA;
                        r.payload_byte = c;
                        payload_left   = payload_left - 10'd1;
                        if (payload_left == '0) rx_state = ST_SKIP;
                    end
                end
                ST_SKIP: begin
                    if (c == CH_NEWLINE) rx_state = ST_IDLE;
                end
                default: begin
                    rx_state = ST_IDLE;
                    if (c == CH_PLUS) begin
                        rx_state  = ST_PLUSTAG;
                        tag_count = '0;
                    end else if (c == CH_E) begin
                        rx_state  = ST_ERRTAG;
                        tag_count = '0;
                    end else if (c == CH_O) begin
                        rx_state = ST_OKWAIT;
                    end
                end
            endcase
            r.link_up     = connected;
            r.parser_idle = (rx_state == ST_IDLE);
            return r;
        endfunction

        function void note_byte(logic [7:0] c);
            expected_results.push_back(parse_byte(c));
        endfunction

        function void check_result(logic [2:0] tuser, logic [23:0] tdata);
            result_t want;
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected, actual tuser %h tdata %h",
                         $time, tuser, tdata);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            results_checked++;
            event_count[want.event_res]++;
            if (tuser !== want.event_res) begin
                $display("%0t: event_res expected %0d actual %0d", $time, want.event_res, tuser);
                mismatches++;
            end
            if (tdata[7:0] !== want.error_code) begin
                $display("%0t: error_code expected %h actual %h",
                         $time, want.error_code, tdata[7:0]);
                mismatches++;
            end
            if (tdata[15:8] !== want.payload_byte) begin
                $display("%0t: payload_byte expected %h actual %h",
                         $time, want.payload_byte, tdata[15:8]);
                mismatches++;
            end
            if (tdata[16] !== want.link_up) begin
                $display("%0t: link_up expected %b actual %b", $time, want.link_up, tdata[16]);
                mismatches++;
            end
            if (tdata[17] !== want.parser_idle) begin
                $display("%0t: parser_idle expected %b actual %b",
                         $time, want.parser_idle, tdata[17]);
                mismatches++;
            end
            if (tdata[23:18] !== 6'd0) begin
                $display("%0t: tdata padding expected 00 actual %h", $time, tdata[23:18]);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;

    parser_scoreboard sb = new();

    logic [7:0] tx_queue [$];
    int         tx_idle_pct  = 0;
    int         rx_stall_pct = 0;
    int         hold_serial  = 0;
    int         hold_taken   = 0;
    int         hold_left    = 0;
    int         bytes_sent   = 0;
    int         cycle_count  = 0;

    bt_module_response_parser uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Result side: check every transfer, stall at random or hold off on request.
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_serial != hold_taken) begin
            hold_taken <= hold_serial;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("bt_module_response_parser: mismatch");
            $finish;
        end
    end

    // Offers one character, with random idle cycles ahead of it, until it is taken.
    task automatic send_byte(input logic [7:0] c);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(c);
        bytes_sent++;
    endtask

    task automatic send_queued();
        while (tx_queue.size() != 0) send_byte(tx_queue.pop_front());
    endtask

    // Stops offering and waits until every predicted result has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_results.size() != 0) @(posedge aclk);
    endtask

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) tx_queue.push_back(s[i]);
    endfunction

    // Up to three stray characters, then the line end.
    function automatic void push_line_end();
        int n;
        n = $urandom_range(3);
        repeat (n) tx_queue.push_back(8'($urandom_range(255)));
        tx_queue.push_back(CH_NEWLINE);
    endfunction

    function automatic logic [7:0] non_digit();
        logic [7:0] c;
        logic [7:0] d;
        do begin
            c = 8'($urandom_range(255));
            d = c - CH_ZERO;
        end while (d <= 8'd9);
        return c;
    endfunction

    // Incoming data response: well formed with random length and content,
    // or broken in the length field.
    function automatic void push_data_response();
        int         pick;
        int         len;
        int         bad_pos;
        logic [7:0] c;
        push_text("+RDAI");
        tx_queue.push_back(($urandom_range(99) < 85) ? 8'h3D : 8'($urandom_range(255)));
        pick = $urandom_range(99);
        if (pick < 10) begin
            push_text("000,");
            push_line_end();
        end else if (pick < 18) begin
            bad_pos = $urandom_range(2);
            repeat (bad_pos) tx_queue.push_back(8'(CH_ZERO + $urandom_range(9)));
            tx_queue.push_back(non_digit());
        end else if (pick < 26) begin
            repeat (3) tx_queue.push_back(8'(CH_ZERO + $urandom_range(9)));
            do c = 8'($urandom_range(255)); while (c == CH_COMMA);
            tx_queue.push_back(c);
        end else begin
            // Long lengths are cut short; what follows is taken as payload.
            len = ($urandom_range(14) == 0) ? $urandom_range(100, 999) : $urandom_range(1, 12);
            tx_queue.push_back(8'(CH_ZERO + len / 100));
            tx_queue.push_back(8'(CH_ZERO + (len / 10) % 10));
            tx_queue.push_back(8'(CH_ZERO + len % 10));
            tx_queue.push_back(CH_COMMA);
            repeat ((len > 30) ? 30 : len) tx_queue.push_back(8'($urandom_range(255)));
            if (len <= 30) push_line_end();
        end
    endfunction

    // Builds one random response line, or a bit of line noise.
    function automatic void push_response();
        string      notify_tags [4];
        int         pick;
        int         sub;
        notify_tags = '{"RSLE", "RCOI", "RCCR", "RDII"};
        pick = $urandom_range(99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 3)) tx_queue.push_back(8'($urandom_range(255)));
        end else if (pick < 22) begin
            tx_queue.push_back(CH_O);
            sub = $urandom_range(99);
            tx_queue.push_back((sub < 55) ? CH_K : (sub < 70) ? CH_NEWLINE :
                               8'($urandom_range(255)));
            push_line_end();
        end else if (pick < 38) begin
            tx_queue.push_back(CH_E);
            if ($urandom_range(99) < 80) begin
                push_text("RR=-");
            end else begin
                push_text("RR=");
                tx_queue.push_back(8'($urandom_range(255)));
            end
            tx_queue.push_back(($urandom_range(99) < 70) ? 8'(CH_ZERO + $urandom_range(9)) :
                               8'($urandom_range(255)));
            push_line_end();
        end else if (pick < 62) begin
            tx_queue.push_back(CH_PLUS);
            push_text(notify_tags[$urandom_range(3)]);
            tx_queue.push_back(8'($urandom_range(255)));
            push_line_end();
        end else if (pick < 70) begin
            // A '+' tag of R and three random capitals, which matches a known tag only by chance.
            tx_queue.push_back(CH_PLUS);
            tx_queue.push_back("R");
            repeat (3) tx_queue.push_back(8'($urandom_range(65, 90)));
            push_line_end();
        end else begin
            push_data_response();
        end
    endfunction

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n_bytes);
        int start;
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            push_response();
            send_queued();
        end
        drain_results();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extreme bytes at idle, ok, an error digit, a zero-length data line.
        tx_queue.push_back(8'h00);
        tx_queue.push_back(8'hFF);
        push_text("OK\n");
        push_text("ERR=-9\n");
        push_text("+RDAI=000,\n");
        send_queued();
        drain_results();

        run_phase(0, 0, PHASE_BYTES);
        run_phase(80, 0, PHASE_BYTES);
        run_phase(0, 80, PHASE_BYTES);
        run_phase(25, 25, PHASE_BYTES);

        // Long receiver hold-off while characters keep coming.
        hold_serial <= hold_serial + 1;
        run_phase(0, 0, 120);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d characters sent, %0d results checked", bytes_sent, sb.results_checked);
        $display("events: ok %0d, error %0d, notify %0d, data %0d; %0d mismatches",
                 sb.event_count[EV_OK], sb.event_count[EV_ERROR],
                 sb.event_count[EV_PAIR] + sb.event_count[EV_INCOMING] +
                 sb.event_count[EV_CONNECTED] + sb.event_count[EV_DISCONNECTED],
                 sb.event_count[EV_DATA], sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("bt_module_response_parser: match");
        end else begin
            $display("bt_module_response_parser: mismatch");
        end
        $finish;
    end

endmodule
